// ===== hw/rtl/plw_pkg.sv =====
package plw_pkg;

  // coordinate width, Q15.16
  localparam int CW = 32;

  // serial multiplier: magnitude of dy times distance to the boundary
  localparam int MUL_AW = CW + 1;
  localparam int MUL_BW = CW;
  localparam int MUL_PW = MUL_AW + MUL_BW - 1;
  localparam int MUL_CW = $clog2(MUL_BW + 1);

  // serial divider: product over denominator, or offset over period
  localparam int DIV_NW = MUL_PW;
  localparam int DIV_DW = CW + 2;
  localparam int DIV_SW = $clog2(DIV_NW + 1);
  localparam logic [DIV_SW-1:0] REM_STEPS = DIV_SW'(CW + 1);
  localparam logic [DIV_SW-1:0] QUO_STEPS = DIV_SW'(DIV_NW);

  // configuration register indexes
  localparam int RIW = 1;
  localparam logic [RIW-1:0] REG_X_LOW  = 1'b0;
  localparam logic [RIW-1:0] REG_X_HIGH = 1'b1;

  // reset values of the wrap boundaries, -180.0 and +180.0
  localparam logic signed [CW-1:0] X_LOW_RST  = -32'sd11796480;
  localparam logic signed [CW-1:0] X_HIGH_RST = 32'sd11796480;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_REM,
    ST_CROSS,
    ST_INTERP,
    ST_MUL,
    ST_DIV,
    ST_YMID,
    ST_OUT_A,
    ST_OUT_BRK,
    ST_OUT_B,
    ST_OUT_PT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
    logic [DIV_SW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] mcand;
    logic [MUL_BW-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_PW-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== hw/rtl/plw_div.sv =====
module plw_div (
  input  logic              clk,
  input  logic              rst_n,
  input  plw_pkg::div_req_t req,
  output plw_pkg::div_rsp_t rsp
);
  import plw_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_SW-1:0] cnt_r;
  logic [DIV_NW-1:0] qr_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] dvs_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, qr_r[DIV_NW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_SW'(1);
        if (cnt_r == DIV_SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out on top, quotient shifts in below
  always_ff @(posedge clk) begin
    if (req.start) begin
      qr_r  <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      qr_r  <= {qr_r[DIV_NW-2:0], ge};
      rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = qr_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== hw/rtl/plw_mul.sv =====
module plw_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  plw_pkg::mul_req_t req,
  output plw_pkg::mul_rsp_t rsp
);
  import plw_pkg::*;

  logic                     busy_r;
  logic                     done_r;
  logic [MUL_CW-1:0]        cnt_r;
  logic [MUL_AW-1:0]        mcand_r;
  logic [MUL_AW+MUL_BW:0]   acc_r;
  logic [MUL_AW:0]          sum;

  // add the multiplicand when the low multiplier bit is set
  assign sum = acc_r[MUL_AW+MUL_BW:MUL_BW]
             + (acc_r[0] ? {1'b0, mcand_r} : {(MUL_AW+1){1'b0}});

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= MUL_CW'(MUL_BW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - MUL_CW'(1);
        if (cnt_r == MUL_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand_r <= req.mcand;
      acc_r   <= {{(MUL_AW+1){1'b0}}, req.mplier};
    end else if (busy_r) begin
      acc_r <= {1'b0, sum, acc_r[MUL_BW-1:1]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r[MUL_PW-1:0];

endmodule

// ===== hw/rtl/polyline_longitude_wrap.sv =====
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_stall  | in_x_coord, in_y_coord, in_is_break
// out      | out_valid / out_stall| out_x_out, out_y_out, out_break,
//          |                      | out_on_boundary, out_last
// cfg      | cfg_we               | cfg_index, cfg_wdata (0 = x_low, 1 = x_high)
//
// one item at a time; a point whose x lies outside the range is first folded
// by a remainder on the period in the serial divider, and a crossing that
// interpolates runs the serial multiplier and then the serial divider.
// reset is synchronous; both boundaries return to -180.0 and +180.0.
// the next item is taken while the last result beat still waits on out_stall.
module polyline_longitude_wrap (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [plw_pkg::CW-1:0]       in_x_coord,
  input  logic signed [plw_pkg::CW-1:0]       in_y_coord,
  input  logic                                in_is_break,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [plw_pkg::CW-1:0]       out_x_out,
  output logic signed [plw_pkg::CW-1:0]       out_y_out,
  output logic                                out_break,
  output logic                                out_on_boundary,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [plw_pkg::RIW-1:0]             cfg_index,
  input  logic [plw_pkg::CW-1:0]              cfg_wdata
);
  import plw_pkg::*;

  state_t state_r, state_nxt;

  logic signed [CW-1:0] x_low_r, x_high_r;
  logic signed [CW-1:0] x_r, y_r, prev_x_r, prev_y_r;
  logic signed [CW-1:0] xa_r, xb_r, bnd_y_r;
  logic                 brk_r, open_r, dyneg_r;
  logic signed [CW:0]   p_r;
  logic                 ppos_r;
  logic [DIV_DW-1:0]    den_r;
  logic [CW:0]          q_r;

  logic                 out_valid_r, out_brk_r, out_bnd_r, out_last_r;
  logic signed [CW-1:0] out_x_r, out_y_r;

  logic                 in_acc, out_free, out_load;
  logic signed [CW-1:0] out_x_nxt, out_y_nxt;
  logic                 out_brk_nxt, out_bnd_nxt, out_last_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic signed [CW:0]   p_w, dx_w, dy_w;
  logic [CW:0]          adx_w, mag_w, off_below_w, off_above_w, tl_w, tr_w;
  logic [CW-1:0]        t_w, rem32_w;
  logic                 x_below, x_above, rem_zero, cross_w, left_w;
  logic signed [CW-1:0] wrap_w;
  logic signed [CW+2:0] den_lft_w, den_rgt_w, den_w, ym_w;
  logic                 den_pos, inc_w, qsat_w;
  logic [CW:0]          q_low_w, q_nxt;
  logic signed [CW-1:0] ym_sat_w;

  // wrap arithmetic
  assign p_w         = {x_high_r[CW-1], x_high_r} - {x_low_r[CW-1], x_low_r};
  assign x_below     = x_r < x_low_r;
  assign x_above     = x_r > x_high_r;
  assign off_below_w = {x_low_r[CW-1], x_low_r} - {x_r[CW-1], x_r};
  assign off_above_w = {x_r[CW-1], x_r} - {x_high_r[CW-1], x_high_r};
  assign rem32_w     = div_rsp.rem[CW-1:0];
  assign rem_zero    = (rem32_w == '0);
  assign wrap_w      = x_below ? (rem_zero ? x_low_r : x_high_r - rem32_w)
                               : (rem_zero ? x_high_r : x_low_r + rem32_w);

  // crossing test: twice the step against the period
  assign dx_w    = {x_r[CW-1], x_r} - {prev_x_r[CW-1], prev_x_r};
  assign adx_w   = dx_w[CW] ? -dx_w : dx_w;
  assign cross_w = open_r && ppos_r && ({adx_w, 1'b0} > {1'b0, p_r});

  // interpolation setup
  assign left_w    = x_r < prev_x_r;
  assign tl_w      = {x_r[CW-1], x_r} - {x_low_r[CW-1], x_low_r};
  assign tr_w      = {x_high_r[CW-1], x_high_r} - {x_r[CW-1], x_r};
  assign t_w       = left_w ? tl_w[CW-1:0] : tr_w[CW-1:0];
  assign den_lft_w = {{3{x_r[CW-1]}}, x_r} + {{2{p_r[CW]}}, p_r}
                   - {{3{prev_x_r[CW-1]}}, prev_x_r};
  assign den_rgt_w = {{2{p_r[CW]}}, p_r} - {{3{x_r[CW-1]}}, x_r}
                   + {{3{prev_x_r[CW-1]}}, prev_x_r};
  assign den_w     = left_w ? den_lft_w : den_rgt_w;
  assign den_pos   = den_w > 35'sd0;
  assign dy_w      = {y_r[CW-1], y_r} - {prev_y_r[CW-1], prev_y_r};
  assign mag_w     = dy_w[CW] ? -dy_w : dy_w;

  // round half away from zero, then clamp the quotient
  assign inc_w   = {div_rsp.rem, 1'b0} >= {1'b0, den_r};
  assign q_low_w = div_rsp.quo[CW:0];
  assign qsat_w  = (|div_rsp.quo[DIV_NW-1:CW+1]) || ((&q_low_w) && inc_w);
  assign q_nxt   = qsat_w ? '1 : q_low_w + {{CW{1'b0}}, inc_w};

  // mid y with saturation to the coordinate range
  assign ym_w = dyneg_r ? {{3{y_r[CW-1]}}, y_r} + {2'b00, q_r}
                        : {{3{y_r[CW-1]}}, y_r} - {2'b00, q_r};
  always_comb begin
    if ((&ym_w[CW+2:CW-1]) || !(|ym_w[CW+2:CW-1])) begin
      ym_sat_w = ym_w[CW-1:0];
    end else if (ym_w[CW+2]) begin
      ym_sat_w = {1'b1, {(CW-1){1'b0}}};
    end else begin
      ym_sat_w = {1'b0, {(CW-1){1'b1}}};
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // next state, unit requests and result beats
  always_comb begin
    state_nxt    = state_r;
    div_req      = '0;
    mul_req      = '0;
    out_load     = 1'b0;
    out_x_nxt    = '0;
    out_y_nxt    = '0;
    out_brk_nxt  = 1'b0;
    out_bnd_nxt  = 1'b0;
    out_last_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_is_break ? ST_OUT_BRK : ST_PREP;
        end
      end
      ST_PREP: begin
        if (ppos_r && (x_below || x_above)) begin
          div_req.start    = 1'b1;
          div_req.dividend = {(x_below ? off_below_w : off_above_w),
                              {(DIV_NW-CW-1){1'b0}}};
          div_req.divisor  = {1'b0, p_r};
          div_req.steps    = REM_STEPS;
          state_nxt        = ST_REM;
        end else begin
          state_nxt = ST_CROSS;
        end
      end
      ST_REM: begin
        if (div_rsp.done) begin
          state_nxt = ST_CROSS;
        end
      end
      ST_CROSS: begin
        if (!cross_w || x_r == x_low_r || x_r == x_high_r) begin
          state_nxt = ST_OUT_PT;
        end else if (prev_x_r == x_low_r || prev_x_r == x_high_r) begin
          state_nxt = ST_OUT_BRK;
        end else begin
          state_nxt = ST_INTERP;
        end
      end
      ST_INTERP: begin
        if (den_pos) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = mag_w;
          mul_req.mplier = t_w;
          state_nxt      = ST_MUL;
        end else begin
          state_nxt = ST_OUT_A;
        end
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_rsp.prod;
          div_req.divisor  = den_r;
          div_req.steps    = QUO_STEPS;
          state_nxt        = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_YMID;
        end
      end
      ST_YMID: begin
        state_nxt = ST_OUT_A;
      end
      ST_OUT_A: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_x_nxt   = xa_r;
          out_y_nxt   = bnd_y_r;
          out_bnd_nxt = 1'b1;
          state_nxt   = ST_OUT_BRK;
        end
      end
      ST_OUT_BRK: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_brk_nxt  = 1'b1;
          out_last_nxt = brk_r;
          state_nxt    = brk_r ? ST_IDLE : ST_OUT_B;
        end
      end
      ST_OUT_B: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_x_nxt   = xb_r;
          out_y_nxt   = bnd_y_r;
          out_bnd_nxt = 1'b1;
          state_nxt   = ST_OUT_PT;
        end
      end
      ST_OUT_PT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_x_nxt    = x_r;
          out_y_nxt    = y_r;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // wrap boundaries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= X_LOW_RST;
      x_high_r <= X_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_LOW:  x_low_r  <= cfg_wdata;
        REG_X_HIGH: x_high_r <= cfg_wdata;
        default:    x_low_r  <= x_low_r;
      endcase
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      prev_x_r <= '0;
      prev_y_r <= '0;
    end else if (in_acc && in_is_break) begin
      open_r <= 1'b0;
    end else if (state_r == ST_OUT_PT && out_free) begin
      open_r   <= 1'b1;
      prev_x_r <= x_r;
      prev_y_r <= y_r;
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_r    <= in_x_coord;
          y_r    <= in_y_coord;
          brk_r  <= in_is_break;
          p_r    <= p_w;
          ppos_r <= p_w > 33'sd0;
        end
      end
      ST_REM: begin
        if (div_rsp.done) begin
          x_r <= wrap_w;
        end
      end
      ST_CROSS: begin
        // a point on a boundary keeps the previous point's side
        if (cross_w && x_r == x_low_r) begin
          x_r <= x_high_r;
        end else if (cross_w && x_r == x_high_r) begin
          x_r <= x_low_r;
        end else if (prev_x_r == x_low_r) begin
          xb_r    <= x_high_r;
          bnd_y_r <= prev_y_r;
        end else if (prev_x_r == x_high_r) begin
          xb_r    <= x_low_r;
          bnd_y_r <= prev_y_r;
        end
      end
      ST_INTERP: begin
        xa_r    <= left_w ? x_high_r : x_low_r;
        xb_r    <= left_w ? x_low_r : x_high_r;
        den_r   <= den_w[DIV_DW-1:0];
        dyneg_r <= dy_w[CW];
        bnd_y_r <= y_r;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          q_r <= q_nxt;
        end
      end
      ST_YMID: begin
        bnd_y_r <= ym_sat_w;
      end
      default: begin
        x_r <= x_r;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r    <= out_x_nxt;
      out_y_r    <= out_y_nxt;
      out_brk_r  <= out_brk_nxt;
      out_bnd_r  <= out_bnd_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_out       = out_x_r;
  assign out_y_out       = out_y_r;
  assign out_break       = out_brk_r;
  assign out_on_boundary = out_bnd_r;
  assign out_last        = out_last_r;

  plw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  plw_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

endmodule

// ===== hw/rtl/plw_checker.sv =====
module plw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [plw_pkg::CW-1:0] out_x_out,
  input logic signed [plw_pkg::CW-1:0] out_y_out,
  input logic                          out_break,
  input logic                          out_on_boundary,
  input logic                          out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_out) && $stable(out_y_out)
      && $stable(out_break) && $stable(out_on_boundary) && $stable(out_last))
    else $error("result beat changed while stalled");

  // separators carry no coordinates
  a_break_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_break |-> out_x_out == '0 && out_y_out == '0 && !out_on_boundary)
    else $error("break beat with coordinates");

  // boundary points always come before the point itself
  a_bnd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_on_boundary |-> !out_last && !out_break)
    else $error("boundary point closes an item");

  // no new item while results of the current one are outstanding
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken with results pending");

  // every accepted item stalls the input in the next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a beat");

endmodule

bind polyline_longitude_wrap plw_checker u_plw_checker (.*);

// ===== verif/polyline_longitude_wrap_test.sv =====
`timescale 1ns / 100ps

module polyline_longitude_wrap_test;
  import plw_pkg::*;

  localparam int DEG = 65536;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 25;
  localparam int HOLD_CYCLES = 400;

  // wrap ranges per phase, the extremes among them
  localparam logic signed [CW-1:0] LO_TAB [PHASES] = '{
    X_LOW_RST, 32'sh8000_0000, 32'sd0, 32'sd5, -32'sd3, 32'sd6553600};
  localparam logic signed [CW-1:0] HI_TAB [PHASES] = '{
    X_HIGH_RST, 32'sh7FFF_FFFF, 32'sd23592960, -32'sd5, 32'sd4, 32'sh7FFF_FFFF};
  localparam int SEND_TAB [PHASES] = '{10, 10, 87, 87, 0, 0};
  localparam int RECV_TAB [PHASES] = '{87, 87, 10, 10, 0, 0};

  typedef struct {
    logic signed [CW-1:0] x_val;
    logic signed [CW-1:0] y_val;
    logic                 brk;
    logic                 bnd;
    logic                 last;
  } beat_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 brk;
    logic                 typed;
    beat_t                want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [CW-1:0] in_x_coord;
  logic signed [CW-1:0] in_y_coord;
  logic                 in_is_break;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [CW-1:0] out_x_out;
  logic signed [CW-1:0] out_y_out;
  logic                 out_break;
  logic                 out_on_boundary;
  logic                 out_last;
  logic                 cfg_we;
  logic [RIW-1:0]       cfg_index;
  logic [CW-1:0]        cfg_wdata;

  // predictor state and register copies
  logic signed [CW-1:0] rng_lo = X_LOW_RST;
  logic signed [CW-1:0] rng_hi = X_HIGH_RST;
  longint               trk_x = 0;
  longint               trk_y = 0;
  bit                   line_open = 1'b0;

  beat_t                staged[$];
  beat_t                beat_q[$];
  row_t                 dir_rows[$];
  int                   fail_count = 0;
  int                   cycle_count = 0;
  int                   send_pct = 0;
  int                   recv_pct = 0;
  bit                   hold_go = 1'b0;

  polyline_longitude_wrap u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_is_break     (in_is_break),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_out       (out_x_out),
    .out_y_out       (out_y_out),
    .out_break       (out_break),
    .out_on_boundary (out_on_boundary),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic beat_t mk_beat(longint x, longint y, logic b, logic n, logic l);
    beat_t bt;
    bt.x_val = x[CW-1:0];
    bt.y_val = y[CW-1:0];
    bt.brk = b;
    bt.bnd = n;
    bt.last = l;
    return bt;
  endfunction

  // y where the segment meets the boundary, quotient rounded half away from zero
  function automatic longint cross_y(longint y, longint py, longint unsigned t, longint den);
    longint dy;
    longint unsigned mag, d, prod, q, rm;
    longint r;
    dy = y - py;
    mag = (dy < 0) ? -dy : dy;
    if (den <= 0) return y;
    d = den;
    prod = mag * t;
    q = prod / d;
    rm = prod % d;
    if (rm >= d - rm) q++;
    if (q > 64'h1_FFFF_FFFF) q = 64'h1_FFFF_FFFF;
    r = (dy >= 0) ? y - longint'(q) : y + longint'(q);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // beats that one input item causes, left in staged
  function automatic void wrap_point(logic signed [CW-1:0] xi, logic signed [CW-1:0] yi,
                                     logic brk);
    longint x, y, lo, hi, p, r, d, den, ym, xa, xb;
    longint unsigned t;
    staged.delete();
    if (brk) begin
      staged.push_back(mk_beat(0, 0, 1'b1, 1'b0, 1'b0));
      line_open = 1'b0;
    end else begin
      x = xi;
      y = yi;
      lo = rng_lo;
      hi = rng_hi;
      p = hi - lo;
      // fold x into the range by a remainder on the period
      if (p > 0) begin
        if (x < lo) begin
          r = (lo - x) % p;
          x = (r == 0) ? lo : lo + p - r;
        end else if (x > hi) begin
          r = (x - hi) % p;
          x = (r == 0) ? hi : hi - p + r;
        end
      end
      // more than half a period from the last point means a crossing
      if (line_open && p > 0) begin
        d = x - trk_x;
        if (d < 0) d = -d;
        if (2 * d > p) begin
          if (x == lo) begin
            x = hi;
          end else if (x == hi) begin
            x = lo;
          end else if (trk_x == lo) begin
            staged.push_back(mk_beat(0, 0, 1'b1, 1'b0, 1'b0));
            staged.push_back(mk_beat(hi, trk_y, 1'b0, 1'b1, 1'b0));
          end else if (trk_x == hi) begin
            staged.push_back(mk_beat(0, 0, 1'b1, 1'b0, 1'b0));
            staged.push_back(mk_beat(lo, trk_y, 1'b0, 1'b1, 1'b0));
          end else begin
            if (x < trk_x) begin
              xa = hi;
              xb = lo;
              t = x - lo;
              den = x + p - trk_x;
            end else begin
              xa = lo;
              xb = hi;
              t = hi - x;
              den = p - x + trk_x;
            end
            ym = cross_y(y, trk_y, t, den);
            staged.push_back(mk_beat(xa, ym, 1'b0, 1'b1, 1'b0));
            staged.push_back(mk_beat(0, 0, 1'b1, 1'b0, 1'b0));
            staged.push_back(mk_beat(xb, ym, 1'b0, 1'b1, 1'b0));
          end
        end
      end
      staged.push_back(mk_beat(x, y, 1'b0, 1'b0, 1'b0));
      trk_x = x;
      trk_y = y;
      line_open = 1'b1;
    end
    staged[staged.size()-1].last = 1'b1;
  endfunction

  function automatic void add_row(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                  logic brk, logic typed, beat_t want);
    row_t rw;
    rw.x = x;
    rw.y = y;
    rw.brk = brk;
    rw.typed = typed;
    rw.want = want;
    dir_rows.push_back(rw);
  endfunction

  // mostly points inside the range and on its edges, some anywhere
  function automatic logic signed [CW-1:0] pick_x();
    longint lo, p;
    lo = rng_lo;
    p = longint'(rng_hi) - lo;
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return rng_lo;
      3: return rng_hi;
      default: begin
        if (p > 0) return CW'(lo + (longint'($urandom) % (p + 1)));
        return CW'(lo + longint'($urandom_range(20)) - 10);
      end
    endcase
  endfunction

  function automatic logic signed [CW-1:0] pick_y();
    if ($urandom_range(1) != 0) return $urandom;
    return $urandom_range(180 * DEG) - 90 * DEG;
  endfunction

  // offer one beat at a falling edge, hold it until taken
  task automatic push_item(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic brk,
                           logic typed, beat_t want);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    in_is_break <= brk;
    do @(posedge clk); while (in_stall);
    wrap_point(x, y, brk);
    if (typed) begin
      beat_q.push_back(want);
    end else begin
      foreach (staged[i]) beat_q.push_back(staged[i]);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (beat_q.size() != 0) @(negedge clk);
  endtask

  // both boundaries, written on consecutive edges
  task automatic set_range(logic signed [CW-1:0] lo, logic signed [CW-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_X_LOW;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= REG_X_HIGH;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    rng_lo = lo;
    rng_hi = hi;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned hold_cnt;
    bit hold_used;
    hold_cnt = 0;
    hold_used = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  // compare each taken result beat with the oldest expectation
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (beat_q.size() == 0) begin
        $display("%0t: unexpected beat x=%0d y=%0d brk=%b bnd=%b last=%b", $time,
                 out_x_out, out_y_out, out_break, out_on_boundary, out_last);
        fail_count++;
      end else begin
        want = beat_q.pop_front();
        if (out_x_out !== want.x_val || out_y_out !== want.y_val ||
            out_break !== want.brk || out_on_boundary !== want.bnd ||
            out_last !== want.last) begin
          $display("%0t: mismatch exp x=%0d y=%0d brk=%b bnd=%b last=%b", $time,
                   want.x_val, want.y_val, want.brk, want.bnd, want.last);
          $display("%0t:          act x=%0d y=%0d brk=%b bnd=%b last=%b", $time,
                   out_x_out, out_y_out, out_break, out_on_boundary, out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats outstanding", $time, beat_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    beat_t none;
    int ph;
    int n;
    none = mk_beat(0, 0, 1'b0, 1'b0, 1'b0);
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_coord = '0;
    in_y_coord = '0;
    in_is_break = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_X_LOW;
    cfg_wdata = '0;

    // directed part at the reset range of -180 to +180
    // breaks before any point and back to back, coordinates ignored
    add_row($urandom, $urandom, 1'b1, 1'b1, mk_beat(0, 0, 1'b1, 1'b0, 1'b1));
    add_row($urandom, $urandom, 1'b1, 1'b1, mk_beat(0, 0, 1'b1, 1'b0, 1'b1));
    // first point of a line, then a short step
    add_row(0, 0, 1'b0, 1'b1, mk_beat(0, 0, 1'b0, 1'b0, 1'b1));
    add_row(170 * DEG, 10 * DEG, 1'b0, 1'b1, mk_beat(170 * DEG, 10 * DEG, 1'b0, 1'b0, 1'b1));
    // interpolated crossing
    add_row(-170 * DEG, 20 * DEG, 1'b0, 1'b0, none);
    // point on the right edge takes the side of the previous point
    add_row(180 * DEG, 30 * DEG, 1'b0, 1'b1,
            mk_beat(-180 * DEG, 30 * DEG, 1'b0, 1'b0, 1'b1));
    // previous point on the left edge
    add_row(170 * DEG, 40 * DEG, 1'b0, 1'b0, none);
    // point on the left edge, then leaving from the right edge
    add_row(-180 * DEG, 5 * DEG, 1'b0, 1'b1, mk_beat(180 * DEG, 5 * DEG, 1'b0, 1'b0, 1'b1));
    add_row(-170 * DEG, 6 * DEG, 1'b0, 1'b0, none);
    // whole periods past the right edge
    add_row(540 * DEG, 0, 1'b0, 1'b0, none);
    add_row(0, 0, 1'b1, 1'b1, mk_beat(0, 0, 1'b1, 1'b0, 1'b1));
    // extremes of x and y, wrapped
    add_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0, none);
    add_row(32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0, none);
    // whole periods below the left edge
    add_row(-900 * DEG, 1, 1'b0, 1'b0, none);
    add_row($urandom, $urandom, 1'b1, 1'b1, mk_beat(0, 0, 1'b1, 1'b0, 1'b1));
    add_row(179 * DEG, 32'sh8000_0000, 1'b0, 1'b1,
            mk_beat(179 * DEG, 32'sh8000_0000, 1'b0, 1'b0, 1'b1));
    // crossing with the widest y swing
    add_row(-179 * DEG, 32'sh7FFF_FFFF, 1'b0, 1'b0, none);
    add_row(-179 * DEG + 1, 1, 1'b0, 1'b0, none);
    add_row(1, -1, 1'b0, 1'b0, none);
    add_row(-1, 32'sh7FFF_FFFF, 1'b0, 1'b0, none);
    add_row(179 * DEG + 5, -7, 1'b0, 1'b0, none);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_pct = SEND_TAB[0];
    recv_pct = RECV_TAB[0];
    foreach (dir_rows[i])
      push_item(dir_rows[i].x, dir_rows[i].y, dir_rows[i].brk, dir_rows[i].typed,
                dir_rows[i].want);
    wait_drained();

    // random lines under each range, the line left open across range changes
    for (ph = 0; ph < PHASES; ph++) begin
      send_pct = SEND_TAB[ph];
      recv_pct = RECV_TAB[ph];
      set_range(LO_TAB[ph], HI_TAB[ph]);
      if (ph == 4) hold_go = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++)
        push_item(pick_x(), pick_y(), $urandom_range(9) == 0, 1'b0, none);
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
